// ===== rtl/core/osdgr_pkg.sv =====
package osdgr_pkg;

    localparam int GLYPH_ROWS  = 16;
    localparam int GLYPH_COUNT = 95;
    localparam int ROM_ROWS    = 16;

    localparam logic [7:0] FIRST_CODE    = 8'h20;
    localparam logic [7:0] LAST_CODE     = 8'h7E;
    localparam logic [7:0] FALLBACK_CODE = 8'h3F;

    // Pixel slots of one glyph row: 8 columns, 4 sub-pixels each at 2x.
    localparam int SLOTS   = 32;
    localparam int SLOT_W  = 5;

    localparam logic [1:0] CFG_LINE_STRIDE  = 2'd0;
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd2;

    localparam logic [12:0] RST_LINE_STRIDE  = 13'd1024;
    localparam logic [12:0] RST_FRAME_WIDTH  = 13'd1024;
    localparam logic [12:0] RST_FRAME_HEIGHT = 13'd600;

    typedef logic [0:ROM_ROWS-1][7:0] t_glyph;

    typedef struct packed {
        logic [12:0] line_stride;
        logic [12:0] frame_width;
        logic [12:0] frame_height;
    } t_cfg;

    // One glyph row, classified: which slots write, plus row bases.
    typedef struct packed {
        logic [SLOTS-1:0]  mask;
        logic [12:0]       origin_x;
        logic              scale;
        logic [23:0]       luma_base0;
        logic [23:0]       luma_base1;
        logic [22:0]       chroma_base0;
        logic [22:0]       chroma_base1;
        logic [7:0]        luma;
        logic [7:0]        v;
        logic [7:0]        u;
    } t_job;

    // Font ROM, row 0 in the top byte, bit 7 is the leftmost pixel.
    function automatic t_glyph glyph_bits(input logic [6:0] idx);
        case (idx)
            7'd0:  glyph_bits = 128'h00000000_00000000_00000000_00000000;
            7'd1:  glyph_bits = 128'h00001818_18181818_18001818_00000000;
            7'd2:  glyph_bits = 128'h00006C6C_6C000000_00000000_00000000;
            7'd3:  glyph_bits = 128'h00003636_7F363636_7F363636_00000000;
            7'd4:  glyph_bits = 128'h0018187E_DBD8D87E_1B1BDB7E_18180000;
            7'd5:  glyph_bits = 128'h00000061_62060C18_30604346_00000000;
            7'd6:  glyph_bits = 128'h0000386C_6C38306F_C6C6CC6B_00000000;
            7'd7:  glyph_bits = 128'h00001818_18000000_00000000_00000000;
            7'd8:  glyph_bits = 128'h00000C18_30303030_3030180C_00000000;
            7'd9:  glyph_bits = 128'h00003018_0C0C0C0C_0C0C1830_00000000;
            7'd10: glyph_bits = 128'h00000000_663CFF3C_66000000_00000000;
            7'd11: glyph_bits = 128'h00000000_181818FF_18181800_00000000;
            7'd12: glyph_bits = 128'h00000000_00000000_00001818_18300000;
            7'd13: glyph_bits = 128'h00000000_000000FF_00000000_00000000;
            7'd14: glyph_bits = 128'h00000000_00000000_00001818_00000000;
            7'd15: glyph_bits = 128'h00000306_060C1818_306060C0_00000000;
            7'd16: glyph_bits = 128'h00003C66_C3C3DBDB_C3C3663C_00000000;
            7'd17: glyph_bits = 128'h00001838_78181818_181818FF_00000000;
            7'd18: glyph_bits = 128'h00007EC3_03060C18_3060C3FF_00000000;
            7'd19: glyph_bits = 128'h00007EC3_03033E03_0303C37E_00000000;
            7'd20: glyph_bits = 128'h0000060E_1E3666C6_FF060606_00000000;
            7'd21: glyph_bits = 128'h0000FFC0_C0C0FE03_0303C37E_00000000;
            7'd22: glyph_bits = 128'h00003E60_C0C0FEC3_C3C3663C_00000000;
            7'd23: glyph_bits = 128'h0000FFC3_03060C18_18181818_00000000;
            7'd24: glyph_bits = 128'h00003C66_C3C3663C_C3C3663C_00000000;
            7'd25: glyph_bits = 128'h00003C66_C3C3C37F_0303067C_00000000;
            7'd26: glyph_bits = 128'h00000000_18180000_00001818_00000000;
            7'd27: glyph_bits = 128'h00000000_18180000_00001818_18300000;
            7'd28: glyph_bits = 128'h00000006_0C183060_30180C06_00000000;
            7'd29: glyph_bits = 128'h00000000_00FF0000_FF000000_00000000;
            7'd30: glyph_bits = 128'h00000060_30180C06_0C183060_00000000;
            7'd31: glyph_bits = 128'h00007EC3_03060C0C_0C000C0C_00000000;
            7'd32: glyph_bits = 128'h00007EC3_036FDBDB_DB6F007E_00000000;
            7'd33: glyph_bits = 128'h0000183C_66C3C3FF_C3C3C3C3_00000000;
            7'd34: glyph_bits = 128'h0000FEC3_C3C3FEC3_C3C3C3FE_00000000;
            7'd35: glyph_bits = 128'h00003C66_C3C0C0C0_C0C3663C_00000000;
            7'd36: glyph_bits = 128'h0000F8CC_C6C3C3C3_C3C6CCF8_00000000;
            7'd37: glyph_bits = 128'h0000FFC0_C0C0FCC0_C0C0C0FF_00000000;
            7'd38: glyph_bits = 128'h0000FFC0_C0C0FCC0_C0C0C0C0_00000000;
            7'd39: glyph_bits = 128'h00003C66_C3C0C0CF_C3C3663C_00000000;
            7'd40: glyph_bits = 128'h0000C3C3_C3C3FFC3_C3C3C3C3_00000000;
            7'd41: glyph_bits = 128'h0000FF18_18181818_181818FF_00000000;
            7'd42: glyph_bits = 128'h00001F06_06060606_06C6C67C_00000000;
            7'd43: glyph_bits = 128'h0000C3C6_CCD8F0F0_D8CCC6C3_00000000;
            7'd44: glyph_bits = 128'h0000C0C0_C0C0C0C0_C0C0C0FF_00000000;
            7'd45: glyph_bits = 128'h0000C3E7_FFDBC3C3_C3C3C3C3_00000000;
            7'd46: glyph_bits = 128'h0000C3E3_F3DBCFC7_C3C3C3C3_00000000;
            7'd47: glyph_bits = 128'h00003C66_C3C3C3C3_C3C3663C_00000000;
            7'd48: glyph_bits = 128'h0000FEC3_C3C3FEC0_C0C0C0C0_00000000;
            7'd49: glyph_bits = 128'h00003C66_C3C3C3C3_C3DB7E3C_07000000;
            7'd50: glyph_bits = 128'h0000FEC3_C3C3FED8_CCC6C3C3_00000000;
            7'd51: glyph_bits = 128'h00007EC3_C0C07E03_0303C37E_00000000;
            7'd52: glyph_bits = 128'h0000FF18_18181818_18181818_00000000;
            7'd53: glyph_bits = 128'h0000C3C3_C3C3C3C3_C3C3C37E_00000000;
            7'd54: glyph_bits = 128'h0000C3C3_C3C3C3C3_C3663C18_00000000;
            7'd55: glyph_bits = 128'h0000C3C3_C3C3C3DB_DBFF6666_00000000;
            7'd56: glyph_bits = 128'h0000C3C3_66663C3C_6666C3C3_00000000;
            7'd57: glyph_bits = 128'h0000C3C3_C3663C18_18181818_00000000;
            7'd58: glyph_bits = 128'h0000FF03_060C1830_60C0C0FF_00000000;
            7'd59: glyph_bits = 128'h00003C30_30303030_3030303C_00000000;
            7'd60: glyph_bits = 128'h0000C060_60301818_0C060603_00000000;
            7'd61: glyph_bits = 128'h00003C0C_0C0C0C0C_0C0C0C3C_00000000;
            7'd62: glyph_bits = 128'h00183C66_C3000000_00000000_00000000;
            7'd63: glyph_bits = 128'h00000000_00000000_00000000_0000FF00;
            7'd64: glyph_bits = 128'h0018180C_00000000_00000000_00000000;
            7'd65: glyph_bits = 128'h00000000_00007E03_7FC3C37F_00000000;
            7'd66: glyph_bits = 128'h0000C0C0_C0DEF3C3_C3C3F3DE_00000000;
            7'd67: glyph_bits = 128'h00000000_00007EC3_C0C0C37E_00000000;
            7'd68: glyph_bits = 128'h00000303_037FC3C3_C3C3C37F_00000000;
            7'd69: glyph_bits = 128'h00000000_00007EC3_FFC0C37E_00000000;
            7'd70: glyph_bits = 128'h00001E33_3030FC30_30303030_00000000;
            7'd71: glyph_bits = 128'h00000000_00007FC3_C3C37F03_C37E0000;
            7'd72: glyph_bits = 128'h0000C0C0_C0DEF3C3_C3C3C3C3_00000000;
            7'd73: glyph_bits = 128'h00001818_00007818_181818FF_00000000;
            7'd74: glyph_bits = 128'h00000606_00003E06_060606C6_C67C0000;
            7'd75: glyph_bits = 128'h0000C0C0_C0C6CCD8_F0D8CCC6_00000000;
            7'd76: glyph_bits = 128'h00007818_18181818_181818FF_00000000;
            7'd77: glyph_bits = 128'h00000000_0000C6EE_FED6C6C6_00000000;
            7'd78: glyph_bits = 128'h00000000_0000DEF3_C3C3C3C3_00000000;
            7'd79: glyph_bits = 128'h00000000_00007EC3_C3C3C37E_00000000;
            7'd80: glyph_bits = 128'h00000000_0000DEF3_C3C3F3DE_C0C00000;
            7'd81: glyph_bits = 128'h00000000_00007FC3_C3C37F03_03030000;
            7'd82: glyph_bits = 128'h00000000_0000DEF3_C0C0C0C0_00000000;
            7'd83: glyph_bits = 128'h00000000_00007EC3_601CC37E_00000000;
            7'd84: glyph_bits = 128'h00003030_30FC3030_3030331E_00000000;
            7'd85: glyph_bits = 128'h00000000_0000C3C3_C3C3C37F_00000000;
            7'd86: glyph_bits = 128'h00000000_0000C3C3_C3663C18_00000000;
            7'd87: glyph_bits = 128'h00000000_0000C3C3_DBDBFF66_00000000;
            7'd88: glyph_bits = 128'h00000000_0000C366_3C3C66C3_00000000;
            7'd89: glyph_bits = 128'h00000000_0000C3C3_C37F03C3_C37E0000;
            7'd90: glyph_bits = 128'h00000000_0000FF06_0C1830FF_00000000;
            7'd91: glyph_bits = 128'h00000E18_18187018_1818180E_00000000;
            7'd92: glyph_bits = 128'h00001818_18181818_18181818_00000000;
            7'd93: glyph_bits = 128'h00007018_18180E18_18181870_00000000;
            7'd94: glyph_bits = 128'h000076DC_00000000_00000000_00000000;
            default: glyph_bits = '0;
        endcase
    endfunction

endpackage

// ===== rtl/core/osd_glyph_row_rasterizer.sv =====
// Throughput: one input beat per cycle while the queue has room; the write engine sends
// one pixel write per cycle while the output is not stalled, and an item has as many
// writes as visible pixels (1 to 32); rows with nothing visible never reach it.
// Reset (synchronous, active low) clears pipeline, queue and output valids and loads
// line_stride 1024, frame_width 1024, frame_height 600; no clearing pass.
module osd_glyph_row_rasterizer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [12:0]        i_cfg_data,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_char_code,
    input  logic [3:0]         i_glyph_row,
    input  logic signed [12:0] i_origin_x,
    input  logic signed [12:0] i_origin_y,
    input  logic               i_scale,
    input  logic [7:0]         i_draw_luma,
    input  logic [7:0]         i_draw_v,
    input  logic [7:0]         i_draw_u,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [23:0]        o_luma_offset,
    output logic [22:0]        o_chroma_offset,
    output logic [7:0]         o_luma_value,
    output logic [7:0]         o_v_value,
    output logic [7:0]         o_u_value,
    output logic               o_last_write
);

    localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1);

    osdgr_pkg::t_cfg      r_cfg, n_cfg;

    logic                 push;
    logic                 pop;
    logic                 empty;
    logic [LEVEL_W-1:0]   level;
    osdgr_pkg::t_job      push_job;
    osdgr_pkg::t_job      head_job;

    // Config registers; the user must write them only while the block is idle; the block does not enforce it.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                osdgr_pkg::CFG_LINE_STRIDE:  n_cfg.line_stride  = i_cfg_data;
                osdgr_pkg::CFG_FRAME_WIDTH:  n_cfg.frame_width  = i_cfg_data;
                osdgr_pkg::CFG_FRAME_HEIGHT: n_cfg.frame_height = i_cfg_data;
                default:                     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_stride  <= osdgr_pkg::RST_LINE_STRIDE;
            r_cfg.frame_width  <= osdgr_pkg::RST_FRAME_WIDTH;
            r_cfg.frame_height <= osdgr_pkg::RST_FRAME_HEIGHT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Front end: accepts a beat, reads the font row, clips every candidate
    // pixel against the frame and forms the row base offsets (2 stages).
    // Its stall comes from a credit count, never from the output side.
    osdgr_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_char_code (i_char_code),
        .i_glyph_row (i_glyph_row),
        .i_origin_x  (i_origin_x),
        .i_origin_y  (i_origin_y),
        .i_scale     (i_scale),
        .i_draw_luma (i_draw_luma),
        .i_draw_v    (i_draw_v),
        .i_draw_u    (i_draw_u),
        .i_level     (level),
        .o_push      (push),
        .o_job       (push_job)
    );

    // Short job queue decoupling classification from pixel emission.
    osdgr_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (empty),
        .o_level (level)
    );

    // Back end: walks the slot mask lowest first, one write per beat,
    // and reloads the next job in the cycle its last write goes out.
    osdgr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job           (head_job),
        .i_empty         (empty),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_luma_offset   (o_luma_offset),
        .o_chroma_offset (o_chroma_offset),
        .o_luma_value    (o_luma_value),
        .o_v_value       (o_v_value),
        .o_u_value       (o_u_value),
        .o_last_write    (o_last_write)
    );

`ifndef SYNTHESIS
    // credit scheme must keep the queue from overflowing
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (level < LEVEL_W'(QUEUE_DEPTH)))
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty)
        else $error("job popped from empty queue");

    // back end relies on every queued job having at least one write
    a_job_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (push_job.mask != '0))
        else $error("empty job entered queue");
`endif

endmodule

// ===== rtl/core/osdgr_front.sv =====
module osdgr_front #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  osdgr_pkg::t_cfg                      i_cfg,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [7:0]                           i_char_code,
    input  logic [3:0]                           i_glyph_row,
    input  logic signed [12:0]                   i_origin_x,
    input  logic signed [12:0]                   i_origin_y,
    input  logic                                 i_scale,
    input  logic [7:0]                           i_draw_luma,
    input  logic [7:0]                           i_draw_v,
    input  logic [7:0]                           i_draw_u,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]     i_level,
    output logic                                 o_push,
    output osdgr_pkg::t_job                      o_job
);

    localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1);

    // stage A: glyph lookup and top screen row
    logic               r_a_valid, n_a_valid;
    logic [7:0]         r_a_bits, n_a_bits;
    logic [13:0]        r_a_py0, n_a_py0;
    logic [12:0]        r_a_ox;
    logic               r_a_scale;
    logic [7:0]         r_a_luma, r_a_v, r_a_u;

    // stage B: slot mask and row bases
    logic               r_b_valid;
    osdgr_pkg::t_job    r_b_job, n_b_job;

    logic               accept;
    logic [7:0]         code;
    logic [6:0]         idx;
    osdgr_pkg::t_glyph  glyph;
    logic [LEVEL_W:0]   occupancy;

    logic [13:0]        x_pos [16];
    logic [15:0]        x_ok;
    logic [13:0]        py1;
    logic               y0_ok, y1_ok;
    logic [27:0]        luma_prod, chroma_prod;
    logic [13:0]        py_half;

    // credit: queue entries plus everything still in the two stages
    assign occupancy  = {1'b0, i_level} + (LEVEL_W+1)'(r_a_valid) + (LEVEL_W+1)'(r_b_valid);
    assign o_in_stall = (occupancy >= (LEVEL_W+1)'(QUEUE_DEPTH));
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        if (i_char_code < osdgr_pkg::FIRST_CODE || i_char_code > osdgr_pkg::LAST_CODE) begin
            code = osdgr_pkg::FALLBACK_CODE;
        end else begin
            code = i_char_code;
        end
        idx   = 7'(code - osdgr_pkg::FIRST_CODE);
        glyph = osdgr_pkg::glyph_bits(idx);
        if (int'(idx) < osdgr_pkg::GLYPH_COUNT && int'(i_glyph_row) < osdgr_pkg::GLYPH_ROWS
            && int'(i_glyph_row) < osdgr_pkg::ROM_ROWS) begin
            n_a_bits = glyph[i_glyph_row];
        end else begin
            n_a_bits = '0;
        end
        if (i_scale) begin
            n_a_py0 = {i_origin_y[12], i_origin_y} + {9'd0, i_glyph_row, 1'b0};
        end else begin
            n_a_py0 = {i_origin_y[12], i_origin_y} + {10'd0, i_glyph_row};
        end
        n_a_valid = accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_bits  <= n_a_bits;
            r_a_py0   <= n_a_py0;
            r_a_ox    <= i_origin_x;
            r_a_scale <= i_scale;
            r_a_luma  <= i_draw_luma;
            r_a_v     <= i_draw_v;
            r_a_u     <= i_draw_u;
        end
    end

    // column clip for the 16 candidate columns
    always_comb begin
        for (int j = 0; j < 16; j++) begin
            x_pos[j] = {r_a_ox[12], r_a_ox} + 14'(j);
            x_ok[j]  = !x_pos[j][13] && (x_pos[j][12:0] < i_cfg.frame_width);
        end
    end

    assign py1   = r_a_py0 + 14'd1;
    assign y0_ok = !r_a_py0[13] && (r_a_py0[12:0] < i_cfg.frame_height);
    assign y1_ok = !py1[13] && (py1[12:0] < i_cfg.frame_height);

    // signed products wrap correctly, so base1 = base0 + stride even at row -1
    assign py_half     = {r_a_py0[13], r_a_py0[13:1]};
    assign luma_prod   = 28'($signed(r_a_py0) * $signed({1'b0, i_cfg.line_stride}));
    assign chroma_prod = 28'($signed(py_half) * $signed({1'b0, i_cfg.line_stride}));

    always_comb begin
        n_b_job = '0;
        for (int c = 0; c < 8; c++) begin
            if (r_a_scale) begin
                for (int s = 0; s < 4; s++) begin
                    n_b_job.mask[4*c+s] = r_a_bits[7-c] & x_ok[2*c+(s%2)]
                                        & ((s >= 2) ? y1_ok : y0_ok);
                end
            end else begin
                n_b_job.mask[c] = r_a_bits[7-c] & x_ok[c] & y0_ok;
            end
        end
        n_b_job.origin_x     = r_a_ox;
        n_b_job.scale        = r_a_scale;
        n_b_job.luma_base0   = luma_prod[23:0];
        n_b_job.luma_base1   = luma_prod[23:0] + {11'd0, i_cfg.line_stride};
        n_b_job.chroma_base0 = chroma_prod[22:0];
        if (r_a_py0[0]) begin
            n_b_job.chroma_base1 = chroma_prod[22:0] + {10'd0, i_cfg.line_stride};
        end else begin
            n_b_job.chroma_base1 = chroma_prod[22:0];
        end
        n_b_job.luma = r_a_luma;
        n_b_job.v    = r_a_v;
        n_b_job.u    = r_a_u;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_valid) begin
            r_b_job <= n_b_job;
        end
    end

    // rows with nothing to draw never enter the queue
    assign o_push = r_b_valid && (r_b_job.mask != '0);
    assign o_job  = r_b_job;

endmodule

// ===== rtl/core/osdgr_fifo.sv =====
module osdgr_fifo #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_push,
    input  osdgr_pkg::t_job                      i_job,
    input  logic                                 i_pop,
    output osdgr_pkg::t_job                      o_job,
    output logic                                 o_empty,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]     o_level
);

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1);

    osdgr_pkg::t_job    r_mem [QUEUE_DEPTH];
    osdgr_pkg::t_job    r_head;
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [LEVEL_W-1:0] r_level, n_level;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            ptr_inc = '0;
        end else begin
            ptr_inc = p + PTR_W'(1);
        end
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_level  = r_level + LEVEL_W'(i_push) - LEVEL_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    // head register reads the next read address; a write landing there bypasses
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
        if (i_push && (n_rd_ptr == r_wr_ptr)) begin
            r_head <= i_job;
        end else begin
            r_head <= r_mem[n_rd_ptr];
        end
    end

    assign o_job   = r_head;
    assign o_empty = (r_level == '0);
    assign o_level = r_level;

endmodule

// ===== rtl/core/osdgr_back.sv =====
module osdgr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  osdgr_pkg::t_job    i_job,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [23:0]        o_luma_offset,
    output logic [22:0]        o_chroma_offset,
    output logic [7:0]         o_luma_value,
    output logic [7:0]         o_v_value,
    output logic [7:0]         o_u_value,
    output logic               o_last_write
);

    osdgr_pkg::t_job                 r_job;
    logic [osdgr_pkg::SLOTS-1:0]     r_mask, n_mask;
    logic                            r_out_valid;
    logic [23:0]                     r_luma_offset, n_luma_offset;
    logic [22:0]                     r_chroma_offset, n_chroma_offset;
    logic [7:0]                      r_luma_value, r_v_value, r_u_value;
    logic                            r_last_write;

    logic                            slot_free;
    logic                            emit;
    logic [osdgr_pkg::SLOT_W-1:0]    slot;
    logic [osdgr_pkg::SLOTS-1:0]     remaining;
    logic [osdgr_pkg::SLOTS-1:0]     mask_after;
    logic [3:0]                      col;
    logic                            dy;
    logic [13:0]                     px;

    assign slot_free  = !r_out_valid || !i_out_stall;
    assign emit       = slot_free && (r_mask != '0);
    assign remaining  = r_mask & (r_mask - osdgr_pkg::SLOTS'(1));
    assign mask_after = emit ? remaining : r_mask;
    assign o_pop      = !i_empty && (mask_after == '0);
    assign n_mask     = o_pop ? i_job.mask : mask_after;

    // lowest pending slot goes first: slot order is output order
    always_comb begin
        slot = '0;
        for (int i = osdgr_pkg::SLOTS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                slot = osdgr_pkg::SLOT_W'(i);
            end
        end
    end

    always_comb begin
        if (r_job.scale) begin
            col = {slot[4:2], slot[0]};
            dy  = slot[1];
        end else begin
            col = {1'b0, slot[2:0]};
            dy  = 1'b0;
        end
        px = {r_job.origin_x[12], r_job.origin_x} + {10'd0, col};
        n_luma_offset   = (dy ? r_job.luma_base1 : r_job.luma_base0) + {11'd0, px[12:0]};
        n_chroma_offset = (dy ? r_job.chroma_base1 : r_job.chroma_base0)
                        + {10'd0, px[12:1], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask <= n_mask;
            if (slot_free) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (emit) begin
            r_luma_offset   <= n_luma_offset;
            r_chroma_offset <= n_chroma_offset;
            r_luma_value    <= r_job.luma;
            r_v_value       <= r_job.v;
            r_u_value       <= r_job.u;
            r_last_write    <= (remaining == '0);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_luma_offset   = r_luma_offset;
    assign o_chroma_offset = r_chroma_offset;
    assign o_luma_value    = r_luma_value;
    assign o_v_value       = r_v_value;
    assign o_u_value       = r_u_value;
    assign o_last_write    = r_last_write;

endmodule

// ===== tb/osd_glyph_row_rasterizer_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels and the register port, predicts every pixel write
// of each accepted glyph row and compares the outgoing beats in order.
module osd_glyph_row_rasterizer_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [12:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [7:0]         i_char_code,
    input  logic [3:0]         i_glyph_row,
    input  logic signed [12:0] i_origin_x,
    input  logic signed [12:0] i_origin_y,
    input  logic               i_scale,
    input  logic [7:0]         i_draw_luma,
    input  logic [7:0]         i_draw_v,
    input  logic [7:0]         i_draw_u,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [23:0]        i_luma_offset,
    input  logic [22:0]        i_chroma_offset,
    input  logic [7:0]         i_luma_value,
    input  logic [7:0]         i_v_value,
    input  logic [7:0]         i_u_value,
    input  logic               i_last_write,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_rows,
    output int                 o_writes
);

    typedef struct packed {
        logic [23:0] luma_off;
        logic [22:0] chroma_off;
        logic [7:0]  y;
        logic [7:0]  v;
        logic [7:0]  u;
        logic        last;
    } t_pixel_write;

    // 8x16 font, glyph 0 is code 0x20; top row in the top byte, bit 7 leftmost.
    localparam logic [0:94][127:0] FONT_ROWS = {
        128'h00000000_00000000_00000000_00000000,
        128'h00001818_18181818_18001818_00000000,
        128'h00006C6C_6C000000_00000000_00000000,
        128'h00003636_7F363636_7F363636_00000000,
        128'h0018187E_DBD8D87E_1B1BDB7E_18180000,
        128'h00000061_62060C18_30604346_00000000,
        128'h0000386C_6C38306F_C6C6CC6B_00000000,
        128'h00001818_18000000_00000000_00000000,
        128'h00000C18_30303030_3030180C_00000000,
        128'h00003018_0C0C0C0C_0C0C1830_00000000,
        128'h00000000_663CFF3C_66000000_00000000,
        128'h00000000_181818FF_18181800_00000000,
        128'h00000000_00000000_00001818_18300000,
        128'h00000000_000000FF_00000000_00000000,
        128'h00000000_00000000_00001818_00000000,
        128'h00000306_060C1818_306060C0_00000000,
        // digits
        128'h00003C66_C3C3DBDB_C3C3663C_00000000,
        128'h00001838_78181818_181818FF_00000000,
        128'h00007EC3_03060C18_3060C3FF_00000000,
        128'h00007EC3_03033E03_0303C37E_00000000,
        128'h0000060E_1E3666C6_FF060606_00000000,
        128'h0000FFC0_C0C0FE03_0303C37E_00000000,
        128'h00003E60_C0C0FEC3_C3C3663C_00000000,
        128'h0000FFC3_03060C18_18181818_00000000,
        128'h00003C66_C3C3663C_C3C3663C_00000000,
        128'h00003C66_C3C3C37F_0303067C_00000000,
        128'h00000000_18180000_00001818_00000000,
        128'h00000000_18180000_00001818_18300000,
        128'h00000006_0C183060_30180C06_00000000,
        128'h00000000_00FF0000_FF000000_00000000,
        128'h00000060_30180C06_0C183060_00000000,
        128'h00007EC3_03060C0C_0C000C0C_00000000,
        // upper case
        128'h00007EC3_036FDBDB_DB6F007E_00000000,
        128'h0000183C_66C3C3FF_C3C3C3C3_00000000,
        128'h0000FEC3_C3C3FEC3_C3C3C3FE_00000000,
        128'h00003C66_C3C0C0C0_C0C3663C_00000000,
        128'h0000F8CC_C6C3C3C3_C3C6CCF8_00000000,
        128'h0000FFC0_C0C0FCC0_C0C0C0FF_00000000,
        128'h0000FFC0_C0C0FCC0_C0C0C0C0_00000000,
        128'h00003C66_C3C0C0CF_C3C3663C_00000000,
        128'h0000C3C3_C3C3FFC3_C3C3C3C3_00000000,
        128'h0000FF18_18181818_181818FF_00000000,
        128'h00001F06_06060606_06C6C67C_00000000,
        128'h0000C3C6_CCD8F0F0_D8CCC6C3_00000000,
        128'h0000C0C0_C0C0C0C0_C0C0C0FF_00000000,
        128'h0000C3E7_FFDBC3C3_C3C3C3C3_00000000,
        128'h0000C3E3_F3DBCFC7_C3C3C3C3_00000000,
        128'h00003C66_C3C3C3C3_C3C3663C_00000000,
        128'h0000FEC3_C3C3FEC0_C0C0C0C0_00000000,
        128'h00003C66_C3C3C3C3_C3DB7E3C_07000000,
        128'h0000FEC3_C3C3FED8_CCC6C3C3_00000000,
        128'h00007EC3_C0C07E03_0303C37E_00000000,
        128'h0000FF18_18181818_18181818_00000000,
        128'h0000C3C3_C3C3C3C3_C3C3C37E_00000000,
        128'h0000C3C3_C3C3C3C3_C3663C18_00000000,
        128'h0000C3C3_C3C3C3DB_DBFF6666_00000000,
        128'h0000C3C3_66663C3C_6666C3C3_00000000,
        128'h0000C3C3_C3663C18_18181818_00000000,
        128'h0000FF03_060C1830_60C0C0FF_00000000,
        128'h00003C30_30303030_3030303C_00000000,
        128'h0000C060_60301818_0C060603_00000000,
        128'h00003C0C_0C0C0C0C_0C0C0C3C_00000000,
        128'h00183C66_C3000000_00000000_00000000,
        128'h00000000_00000000_00000000_0000FF00,
        // lower case
        128'h0018180C_00000000_00000000_00000000,
        128'h00000000_00007E03_7FC3C37F_00000000,
        128'h0000C0C0_C0DEF3C3_C3C3F3DE_00000000,
        128'h00000000_00007EC3_C0C0C37E_00000000,
        128'h00000303_037FC3C3_C3C3C37F_00000000,
        128'h00000000_00007EC3_FFC0C37E_00000000,
        128'h00001E33_3030FC30_30303030_00000000,
        128'h00000000_00007FC3_C3C37F03_C37E0000,
        128'h0000C0C0_C0DEF3C3_C3C3C3C3_00000000,
        128'h00001818_00007818_181818FF_00000000,
        128'h00000606_00003E06_060606C6_C67C0000,
        128'h0000C0C0_C0C6CCD8_F0D8CCC6_00000000,
        128'h00007818_18181818_181818FF_00000000,
        128'h00000000_0000C6EE_FED6C6C6_00000000,
        128'h00000000_0000DEF3_C3C3C3C3_00000000,
        128'h00000000_00007EC3_C3C3C37E_00000000,
        128'h00000000_0000DEF3_C3C3F3DE_C0C00000,
        128'h00000000_00007FC3_C3C37F03_03030000,
        128'h00000000_0000DEF3_C0C0C0C0_00000000,
        128'h00000000_00007EC3_601CC37E_00000000,
        128'h00003030_30FC3030_3030331E_00000000,
        128'h00000000_0000C3C3_C3C3C37F_00000000,
        128'h00000000_0000C3C3_C3663C18_00000000,
        128'h00000000_0000C3C3_DBDBFF66_00000000,
        128'h00000000_0000C366_3C3C66C3_00000000,
        128'h00000000_0000C3C3_C37F03C3_C37E0000,
        128'h00000000_0000FF06_0C1830FF_00000000,
        128'h00000E18_18187018_1818180E_00000000,
        128'h00001818_18181818_18181818_00000000,
        128'h00007018_18180E18_18181870_00000000,
        128'h000076DC_00000000_00000000_00000000
    };

    logic [12:0]  stride_reg;
    logic [12:0]  width_reg;
    logic [12:0]  height_reg;
    t_pixel_write pixel_writes_due[$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_rows    = 0;
        o_writes  = 0;
    end

    task automatic report_mismatch(input string msg);
        o_errors = o_errors + 1;
        if (o_errors <= 100) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
    endtask

    // Expands one glyph row into its visible pixel writes, in column order.
    // The newest write is held back so the final one can carry the last flag.
    function automatic void rasterize_row(input logic [7:0] code, input logic [3:0] row,
                                          input int ox, input int oy, input logic dbl,
                                          input logic [7:0] y, input logic [7:0] v,
                                          input logic [7:0] u);
        logic [7:0]   glyph_code;
        logic [7:0]   bits;
        int           mult;
        int           nsub;
        int           px;
        int           py;
        longint       luma_lin;
        longint       chroma_lin;
        t_pixel_write wr;
        t_pixel_write held;
        bit           have_held;

        glyph_code = code;
        if (code < osdgr_pkg::FIRST_CODE || code > osdgr_pkg::LAST_CODE) begin
            glyph_code = osdgr_pkg::FALLBACK_CODE;  // unknown codes draw '?'
        end
        bits      = FONT_ROWS[glyph_code - osdgr_pkg::FIRST_CODE][127 - 8 * row -: 8];
        mult      = dbl ? 2 : 1;
        nsub      = dbl ? 4 : 1;
        have_held = 1'b0;
        held      = '0;

        for (int col = 0; col < 8; col++) begin
            if (bits[7 - col]) begin
                for (int sub = 0; sub < nsub; sub++) begin
                    px = ox + mult * col + (sub & 1);
                    py = oy + mult * int'(row) + (sub >> 1);
                    if (px >= 0 && py >= 0 && px < int'(width_reg) && py < int'(height_reg)) begin
                        luma_lin   = longint'(py) * int'(stride_reg) + px;
                        chroma_lin = longint'(py >> 1) * int'(stride_reg) + (px & ~1);
                        wr.luma_off   = luma_lin[23:0];
                        wr.chroma_off = chroma_lin[22:0];
                        wr.y          = y;
                        wr.v          = v;
                        wr.u          = u;
                        wr.last       = 1'b0;
                        if (have_held) begin
                            pixel_writes_due.push_back(held);
                        end
                        held      = wr;
                        have_held = 1'b1;
                    end
                end
            end
        end
        if (have_held) begin
            held.last = 1'b1;
            pixel_writes_due.push_back(held);
        end
    endfunction

    always @(posedge i_clk) begin
        t_pixel_write due;
        if (!i_rst_n) begin
            stride_reg = osdgr_pkg::RST_LINE_STRIDE;
            width_reg  = osdgr_pkg::RST_FRAME_WIDTH;
            height_reg = osdgr_pkg::RST_FRAME_HEIGHT;
            pixel_writes_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_writes = o_writes + 1;
                if (pixel_writes_due.size() == 0) begin
                    report_mismatch($sformatf("write %0d with nothing due (luma_offset %0h)",
                                              o_writes, i_luma_offset));
                end else begin
                    due = pixel_writes_due.pop_front();
                    if (i_luma_offset !== due.luma_off)
                        report_mismatch($sformatf("write %0d luma_offset %0h, want %0h",
                                                  o_writes, i_luma_offset, due.luma_off));
                    if (i_chroma_offset !== due.chroma_off)
                        report_mismatch($sformatf("write %0d chroma_offset %0h, want %0h",
                                                  o_writes, i_chroma_offset, due.chroma_off));
                    if (i_luma_value !== due.y)
                        report_mismatch($sformatf("write %0d luma_value %0h, want %0h",
                                                  o_writes, i_luma_value, due.y));
                    if (i_v_value !== due.v)
                        report_mismatch($sformatf("write %0d v_value %0h, want %0h",
                                                  o_writes, i_v_value, due.v));
                    if (i_u_value !== due.u)
                        report_mismatch($sformatf("write %0d u_value %0h, want %0h",
                                                  o_writes, i_u_value, due.u));
                    if (i_last_write !== due.last)
                        report_mismatch($sformatf("write %0d last_write %b, want %b",
                                                  o_writes, i_last_write, due.last));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                o_rows = o_rows + 1;
                rasterize_row(i_char_code, i_glyph_row, int'(i_origin_x), int'(i_origin_y),
                              i_scale, i_draw_luma, i_draw_v, i_draw_u);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    osdgr_pkg::CFG_LINE_STRIDE:  stride_reg = i_cfg_data;
                    osdgr_pkg::CFG_FRAME_WIDTH:  width_reg  = i_cfg_data;
                    osdgr_pkg::CFG_FRAME_HEIGHT: height_reg = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = pixel_writes_due.size();
    end

endmodule

// ===== tb/osd_glyph_row_rasterizer_tb.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the glyph row rasterizer. The checker beside the
// block does all prediction; this module only shapes beats and settings.
module osd_glyph_row_rasterizer_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off to back up the queue
    localparam int SETTLE      = 12;    // waits out rows still in flight after the last due write

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [12:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         char_code;
    logic [3:0]         glyph_row;
    logic signed [12:0] origin_x;
    logic signed [12:0] origin_y;
    logic               scale;
    logic [7:0]         draw_luma;
    logic [7:0]         draw_v;
    logic [7:0]         draw_u;
    logic               out_valid;
    logic               out_stall;
    logic [23:0]        luma_offset;
    logic [22:0]        chroma_offset;
    logic [7:0]         luma_value;
    logic [7:0]         v_value;
    logic [7:0]         u_value;
    logic               last_write;

    int  chk_errors;
    int  chk_pending;
    int  chk_rows;
    int  chk_writes;
    int  cycle_count = 0;
    int  tx_idle_pct;
    int  rx_idle_pct;
    int  frame_w;
    int  frame_h;
    int  settings_run = 1;
    bit  hold_req = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    osd_glyph_row_rasterizer u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_char_code     (char_code),
        .i_glyph_row     (glyph_row),
        .i_origin_x      (origin_x),
        .i_origin_y      (origin_y),
        .i_scale         (scale),
        .i_draw_luma     (draw_luma),
        .i_draw_v        (draw_v),
        .i_draw_u        (draw_u),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_luma_offset   (luma_offset),
        .o_chroma_offset (chroma_offset),
        .o_luma_value    (luma_value),
        .o_v_value       (v_value),
        .o_u_value       (u_value),
        .o_last_write    (last_write)
    );

    osd_glyph_row_rasterizer_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_char_code     (char_code),
        .i_glyph_row     (glyph_row),
        .i_origin_x      (origin_x),
        .i_origin_y      (origin_y),
        .i_scale         (scale),
        .i_draw_luma     (draw_luma),
        .i_draw_v        (draw_v),
        .i_draw_u        (draw_u),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_luma_offset   (luma_offset),
        .i_chroma_offset (chroma_offset),
        .i_luma_value    (luma_value),
        .i_v_value       (v_value),
        .i_u_value       (u_value),
        .i_last_write    (last_write),
        .o_errors        (chk_errors),
        .o_pending       (chk_pending),
        .o_rows          (chk_rows),
        .o_writes        (chk_writes)
    );

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d writes still due", cycle_count, chk_pending);
            $display("osd_glyph_row_rasterizer verification failed");
            $finish;
        end
    end

    // Receiver. Random stalls at the current rate; on request it holds off
    // for a long stretch, counting cycles itself, while the sender keeps going.
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input int val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[12:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Drains all due writes, then waits out rows that may still be in flight
    // with nothing visible (they never show up on the output).
    task automatic settle();
        @(negedge clk);
        while (chk_pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // One input beat. Optional idle cycles first, then hold until accepted.
    task automatic send_row(input logic [7:0] code, input logic [3:0] row, input int ox,
                            input int oy, input logic dbl, input logic [7:0] y,
                            input logic [7:0] v, input logic [7:0] u);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        char_code <= code;
        glyph_row <= row;
        origin_x  <= ox[12:0];
        origin_y  <= oy[12:0];
        scale     <= dbl;
        draw_luma <= y;
        draw_v    <= v;
        draw_u    <= u;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Mostly on-screen origins, some hugging the far edge or just off the
    // near edge, and a tenth anywhere in the signed range.
    function automatic int pick_coord(input int extent);
        int r;
        int hi;
        int v;
        r  = $urandom_range(0, 99);
        hi = (extent > 4095) ? 4095 : extent;
        if (r < 65)
            v = $urandom_range(0, hi);
        else if (r < 80)
            v = hi - int'($urandom_range(0, 20));
        else if (r < 90)
            v = -int'($urandom_range(1, 20));
        else
            v = int'($urandom_range(0, 8191)) - 4096;
        return v;
    endfunction

    task automatic send_random_row();
        logic [7:0] code;
        logic [3:0] row;
        // mostly printable; the rest covers the fallback glyph
        code = 8'(($urandom_range(0, 99) < 80) ? $urandom_range(8'h20, 8'h7E)
                                                : $urandom_range(0, 255));
        // rows 2..11 carry most of the ink
        row  = 4'(($urandom_range(0, 99) < 75) ? $urandom_range(2, 11)
                                                : $urandom_range(0, 15));
        send_row(code, row, pick_coord(frame_w), pick_coord(frame_h),
                 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic run_setting(input int stride, input int width, input int height,
                               input int n_rows, input int tx_pct, input int rx_pct,
                               input bit with_hold);
        settle();
        write_reg(osdgr_pkg::CFG_LINE_STRIDE, stride);
        write_reg(osdgr_pkg::CFG_FRAME_WIDTH, width);
        write_reg(osdgr_pkg::CFG_FRAME_HEIGHT, height);
        frame_w      = width;
        frame_h      = height;
        tx_idle_pct  = tx_pct;
        rx_idle_pct  = rx_pct;
        settings_run = settings_run + 1;
        if (with_hold) begin
            @(posedge clk);
            hold_req = 1'b1;
        end
        repeat (n_rows) send_random_row();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Directed rows at the reset frame (1024 x 600, stride 1024).
    task automatic run_directed();
        send_row(8'h41, 4'd7, 0, 0, 1'b0, 8'hFF, 8'h00, 8'hFF);        // full row, 1x
        send_row(8'h41, 4'd7, 0, 0, 1'b1, 8'h00, 8'hFF, 8'h00);        // 32 writes at 2x
        send_row(8'h00, 4'd2, 100, 50, 1'b0, 8'hAA, 8'h55, 8'hAA);     // unknown code, low
        send_row(8'hFF, 4'd3, 101, 51, 1'b1, 8'h55, 8'hAA, 8'h55);     // unknown, odd origin
        send_row(8'h1F, 4'd5, 200, 20, 1'b0, 8'h12, 8'h34, 8'h56);     // just below space
        send_row(8'h7F, 4'd4, 200, 21, 1'b1, 8'h78, 8'h9A, 8'hBC);     // just above tilde
        send_row(8'h20, 4'd5, 10, 10, 1'b1, 8'hFF, 8'hFF, 8'hFF);      // space: no writes
        send_row(8'h7E, 4'd2, 300, 100, 1'b0, 8'h01, 8'h80, 8'hFE);
        send_row(8'h7E, 4'd3, 300, 100, 1'b1, 8'h7F, 8'h01, 8'h80);
        send_row(8'h48, 4'd0, 10, 10, 1'b0, 8'hFF, 8'h00, 8'h00);      // empty top row
        send_row(8'h48, 4'd15, 10, 10, 1'b1, 8'h00, 8'hFF, 8'h00);     // empty bottom row
        send_row(8'h4D, 4'd5, -3, 10, 1'b0, 8'h33, 8'hCC, 8'h33);      // clipped on the left
        send_row(8'h23, 4'd7, 0, -15, 1'b1, 8'hCC, 8'h33, 8'hCC);      // half above the top
        send_row(8'h48, 4'd6, 1020, 587, 1'b1, 8'h0F, 8'hF0, 8'h0F);   // right and bottom clip
        send_row(8'h48, 4'd6, -4096, -4096, 1'b1, 8'hF0, 8'h0F, 8'hF0);
        send_row(8'h48, 4'd6, 4095, 4095, 1'b0, 8'hFF, 8'hFF, 8'h00);
        send_row(8'h48, 4'd6, -1, -1, 1'b1, 8'h00, 8'h00, 8'hFF);
        send_row(8'h5F, 4'd14, 1016, 570, 1'b1, 8'hA5, 8'h5A, 8'hA5);  // underscore at edge
        send_row(8'h57, 4'd9, 512, 300, 1'b1, 8'h55, 8'hAA, 8'h55);
        send_row(8'h7B, 4'd6, 1023, 599, 1'b0, 8'h10, 8'h20, 8'h30);   // all past the edge
        send_row(8'h40, 4'd5, 700, 400, 1'b1, 8'hEE, 8'h11, 8'hEE);
        send_row(8'h31, 4'd11, 1365, 2730, 1'b0, 8'h11, 8'hEE, 8'h11); // beyond the frame
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    initial begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = osdgr_pkg::CFG_LINE_STRIDE;
        cfg_data    = '0;
        in_valid    = 1'b0;
        char_code   = '0;
        glyph_row   = '0;
        origin_x    = '0;
        origin_y    = '0;
        scale       = 1'b0;
        draw_luma   = '0;
        draw_v      = '0;
        draw_u      = '0;
        tx_idle_pct = 28;
        rx_idle_pct = 81;
        frame_w     = 1024;
        frame_h     = 600;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        // sender sparse, receiver stalling hard
        run_setting(1024, 640, 480, 60, 28, 81, 1'b0);
        run_setting(8191, 4096, 4096, 60, 28, 81, 1'b0);  // offsets wrap
        run_setting(0, 0, 600, 10, 28, 81, 1'b0);         // zero width clips all
        run_setting(1, 8191, 0, 10, 28, 81, 1'b0);        // zero height clips all
        // roles swapped
        run_setting(4096, 4096, 4096, 60, 81, 28, 1'b0);
        run_setting(24, 20, 10, 50, 81, 28, 1'b0);        // tiny frame, heavy clipping
        // full rate both sides, then a long receiver hold-off
        run_setting(0, 8191, 8191, 50, 0, 0, 1'b0);
        run_setting(1024, 1024, 600, 70, 0, 0, 1'b1);

        @(negedge clk);
        while (chk_pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);

        $display("%0d glyph rows sent across %0d register settings, %0d pixel writes compared",
                 chk_rows, settings_run, chk_writes);
        $display("fallback glyph, clipping on all four sides, zero-size frames and offset wrap");
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("osd_glyph_row_rasterizer verification clean");
        end else begin
            $display("osd_glyph_row_rasterizer verification failed");
        end
        $finish;
    end

endmodule
